// File: src/xosh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package xosh_pkg;

    localparam int WordWidth = 64;
    localparam int HalfWidth = 32;
    localparam int SeedWidth = 32;
    localparam int FracWidth = 53;
    localparam int FracShift = WordWidth - FracWidth;
    localparam int NumWords  = 4;
    localparam int IdxWidth  = $clog2(NumWords);

    localparam logic [WordWidth-1:0] MixGamma = 64'h9e3779b97f4a7c15;
    localparam logic [WordWidth-1:0] MixMulA  = 64'hbf58476d1ce4e5b9;
    localparam logic [WordWidth-1:0] MixMulB  = 64'h94d049bb133111eb;

    localparam int XorShift = 17;
    localparam int RotLeft  = 45;

    // steps of one 64x64 low-half multiply on the shared 32x32 unit
    typedef enum logic [1:0] {
        MUL_LL    = 2'd0,
        MUL_HL    = 2'd1,
        MUL_LH    = 2'd2,
        MUL_FINAL = 2'd3
    } mul_step_t;

    // which splitmix multiply constant is in use
    typedef enum logic {
        SEL_MUL_A = 1'b0,
        SEL_MUL_B = 1'b1
    } mul_sel_t;

    typedef struct packed {
        logic                load_seed;
        logic                add_gamma;
        logic                mul_run;
        mul_step_t           mul_step;
        mul_sel_t            mul_sel;
        logic [IdxWidth-1:0] word_idx;
        logic                draw;
    } xosh_cmd_t;

    typedef struct packed {
        logic out_blocked;
    } xosh_status_t;

endpackage

`default_nettype wire

// File: src/xoshiro256plus_generator_top.sv
// draw: result registered and valid on the next edge after the transfer
// draws sustain one transfer per cycle while the output side keeps taking results
// seed: busy after the transfer while 4 words are made, each by one add and two
//   64-bit multiplies of 4 steps each on the shared 32x32 multiplier; no result
// reset (rst_n low, async): generator words zero, controller idle, output empty
`timescale 1ns / 1ps
`default_nettype none

module xoshiro256plus_generator_top (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // input channel
    input  wire logic                                  in_valid,
    output      logic                                  in_stall,
    input  wire logic                                  mode,
    input  wire logic signed [xosh_pkg::SeedWidth-1:0] seed_value,
    // result channel
    output      logic                                  out_valid,
    input  wire logic                                  out_stall,
    output      logic [xosh_pkg::WordWidth-1:0]        raw_value,
    output      logic [xosh_pkg::FracWidth-1:0]        uniform_fraction
);
    import xosh_pkg::*;

    xosh_cmd_t    cmd;
    xosh_status_t status;
    logic         busy;

    // controller: accepts transfers, sequences the splitmix seeding
    xosh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode),
        .status   (status),
        .in_stall (in_stall),
        .busy     (busy),
        .cmd      (cmd)
    );

    // datapath: generator words, seeding arithmetic, result register
    xosh_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .seed_value       (seed_value),
        .out_stall        (out_stall),
        .status           (status),
        .out_valid        (out_valid),
        .raw_value        (raw_value),
        .uniform_fraction (uniform_fraction)
    );

    // a seed transfer starts the seeding sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !mode) |=> busy)
        else $error("seed transfer did not start seeding");

    // a draw transfer always presents a result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && mode) |=> out_valid)
        else $error("draw transfer produced no result");

    // a draw never leaves the controller busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && mode) |=> !busy)
        else $error("draw transfer started a seeding sequence");

    // the fraction is the top bits of the raw sum
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (uniform_fraction == raw_value[WordWidth-1:FracShift]))
        else $error("fraction does not match raw value");

endmodule

`default_nettype wire

// File: src/xosh_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module xosh_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 mode,
    input  wire xosh_pkg::xosh_status_t status,
    output      logic                 in_stall,
    output      logic                 busy,
    output      xosh_pkg::xosh_cmd_t  cmd
);
    import xosh_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_ADD  = 3'b010,
        S_MUL  = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    mul_step_t           step_reg, step_next;
    mul_sel_t            sel_reg, sel_next;
    logic [IdxWidth-1:0] idx_reg, idx_next;
    logic                in_accept;

    assign busy      = (state_reg != S_IDLE);
    assign in_stall  = busy || status.out_blocked;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        sel_next      = sel_reg;
        idx_next      = idx_reg;
        cmd.load_seed = 1'b0;
        cmd.add_gamma = 1'b0;
        cmd.mul_run   = 1'b0;
        cmd.mul_step  = step_reg;
        cmd.mul_sel   = sel_reg;
        cmd.word_idx  = idx_reg;
        cmd.draw      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (mode)
                    begin
                        cmd.draw = 1'b1;
                    end
                    else
                    begin
                        cmd.load_seed = 1'b1;
                        idx_next      = '0;
                        state_next    = S_ADD;
                    end
                end
            end
            S_ADD:
            begin
                cmd.add_gamma = 1'b1;
                step_next     = MUL_LL;
                sel_next      = SEL_MUL_A;
                state_next    = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_run = 1'b1;
                unique case (step_reg)
                    MUL_LL:    step_next = MUL_HL;
                    MUL_HL:    step_next = MUL_LH;
                    MUL_LH:    step_next = MUL_FINAL;
                    MUL_FINAL:
                    begin
                        step_next = MUL_LL;
                        if (sel_reg == SEL_MUL_A)
                        begin
                            sel_next = SEL_MUL_B;
                        end
                        else if (idx_reg == IdxWidth'(NumWords - 1))
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = S_ADD;
                        end
                    end
                    default:   step_next = MUL_LL;
                endcase
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= MUL_LL;
            sel_reg   <= SEL_MUL_A;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            sel_reg   <= sel_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

`default_nettype wire

// File: src/xosh_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module xosh_dp (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire xosh_pkg::xosh_cmd_t                   cmd,
    input  wire logic signed [xosh_pkg::SeedWidth-1:0] seed_value,
    input  wire logic                                  out_stall,
    output      xosh_pkg::xosh_status_t                status,
    output      logic                                  out_valid,
    output      logic [xosh_pkg::WordWidth-1:0]        raw_value,
    output      logic [xosh_pkg::FracWidth-1:0]        uniform_fraction
);
    import xosh_pkg::*;

    logic [WordWidth-1:0] words_reg [NumWords];
    logic [WordWidth-1:0] acc_reg;
    logic [WordWidth-1:0] z_reg;
    logic [WordWidth-1:0] prod_reg;
    logic [WordWidth-1:0] mul_reg;
    logic [WordWidth-1:0] raw_reg;
    logic                 out_valid_reg, out_valid_next;

    logic [WordWidth-1:0] acc_sum;
    logic [WordWidth-1:0] mul_const;
    logic [HalfWidth-1:0] mul_a, mul_b;
    logic [WordWidth-1:0] mul_prod;
    logic [WordWidth-1:0] mul_done;
    logic [WordWidth-1:0] draw_sum;
    logic [WordWidth-1:0] w0_n, w1_n, w2_n, w3_n, w3_x;

    assign acc_sum   = acc_reg + MixGamma;
    assign mul_const = (cmd.mul_sel == SEL_MUL_B) ? MixMulB : MixMulA;

    always_comb
    begin
        unique case (cmd.mul_step)
            MUL_LL:
            begin
                mul_a = z_reg[HalfWidth-1:0];
                mul_b = mul_const[HalfWidth-1:0];
            end
            MUL_HL:
            begin
                mul_a = z_reg[WordWidth-1:HalfWidth];
                mul_b = mul_const[HalfWidth-1:0];
            end
            default:
            begin
                mul_a = z_reg[HalfWidth-1:0];
                mul_b = mul_const[WordWidth-1:HalfWidth];
            end
        endcase
    end

    assign mul_prod = mul_a * mul_b;
    // low half of z * const: low product plus both cross terms shifted up
    assign mul_done = prod_reg + {mul_reg[HalfWidth-1:0], {HalfWidth{1'b0}}};

    // xoshiro256 transition
    assign draw_sum = words_reg[0] + words_reg[3];
    assign w2_n     = words_reg[2] ^ words_reg[0];
    assign w3_x     = words_reg[3] ^ words_reg[1];
    assign w1_n     = words_reg[1] ^ w2_n;
    assign w0_n     = words_reg[0] ^ w3_x;
    assign w3_n     = {w3_x[WordWidth-RotLeft-1:0], w3_x[WordWidth-1:WordWidth-RotLeft]};

    always_ff @(posedge clk)
    begin
        if (cmd.load_seed)
        begin
            acc_reg <= {{(WordWidth-SeedWidth){seed_value[SeedWidth-1]}}, seed_value};
        end
        else if (cmd.add_gamma)
        begin
            acc_reg <= acc_sum;
        end
        if (cmd.add_gamma)
        begin
            z_reg <= acc_sum ^ (acc_sum >> 30);
        end
        if (cmd.mul_run)
        begin
            mul_reg <= mul_prod;
            unique case (cmd.mul_step)
                MUL_LL:    ;
                MUL_HL:    prod_reg <= mul_reg;
                MUL_LH:
                begin
                    prod_reg[WordWidth-1:HalfWidth] <=
                        prod_reg[WordWidth-1:HalfWidth] + mul_reg[HalfWidth-1:0];
                end
                MUL_FINAL:
                begin
                    if (cmd.mul_sel == SEL_MUL_A)
                    begin
                        z_reg <= mul_done ^ (mul_done >> 27);
                    end
                end
                default:   ;
            endcase
        end
        if (cmd.draw)
        begin
            raw_reg <= draw_sum;
        end
    end

    // generator words reset to zero so draws before a seed return zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NumWords; i++)
            begin
                words_reg[i] <= '0;
            end
        end
        else if (cmd.draw)
        begin
            words_reg[0] <= w0_n;
            words_reg[1] <= w1_n;
            words_reg[2] <= w2_n ^ (words_reg[1] << XorShift);
            words_reg[3] <= w3_n;
        end
        else if (cmd.mul_run && cmd.mul_step == MUL_FINAL && cmd.mul_sel == SEL_MUL_B)
        begin
            words_reg[cmd.word_idx] <= mul_done ^ (mul_done >> 31);
        end
    end

    assign out_valid_next = cmd.draw || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.out_blocked = out_valid_reg && out_stall;
    assign out_valid          = out_valid_reg;
    assign raw_value          = raw_reg;
    assign uniform_fraction   = raw_reg[WordWidth-1:FracShift];

endmodule

`default_nettype wire

// File: sim/xoshiro256plus_generator_top_tb.sv
`timescale 1ns / 1ps

module xoshiro256plus_generator_top_tb;

    import xosh_pkg::*;

    // item codes on the mode field
    localparam logic ModeSeed = 1'b0;
    localparam logic ModeDraw = 1'b1;

    // receiver hold-off used to back the block up into its input
    localparam int RxHoldCycles  = 300;
    // cycles with no transfer on either channel before the run is abandoned
    localparam int WatchdogLimit = 4000;
    // settle time at the end: lets a trailing seed finish its busy sequence
    localparam int DrainCycles   = 60;
    localparam int MaxReported   = 10;

    typedef struct packed {
        logic                        mode;
        logic signed [SeedWidth-1:0] seed;
    } gen_item_t;

    typedef struct packed {
        logic [WordWidth-1:0] raw;
        logic [FracWidth-1:0] frac;
    } draw_result_t;

    // dut ports; the driven inputs are known from time zero
    logic                        clk        = 1'b0;
    logic                        rst_n      = 1'b0;
    logic                        in_valid   = 1'b0;
    logic                        in_stall;
    logic                        mode       = ModeSeed;
    logic signed [SeedWidth-1:0] seed_value = '0;
    logic                        out_valid;
    logic                        out_stall  = 1'b0;
    logic [WordWidth-1:0]        raw_value;
    logic [FracWidth-1:0]        uniform_fraction;

    // items waiting to be offered, and draws waiting for their result
    gen_item_t    pending_items[$];
    draw_result_t expected_draws[$];

    // predicted generator state
    logic [WordWidth-1:0] gen_words[NumWords];

    // idle percentages of the two sides for the current phase
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // hold-off requests: bumped by the stimulus, served by the receiver process
    int hold_ticket = 0;
    int hold_served = 0;
    int hold_left   = 0;

    int mismatch_count = 0;
    int stalled_cycles = 0;

    gen_item_t next_item;

    xoshiro256plus_generator_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .mode             (mode),
        .seed_value       (seed_value),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .raw_value        (raw_value),
        .uniform_fraction (uniform_fraction)
    );

    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // one splitmix64 output, advancing the accumulator
    task automatic splitmix_next(inout logic [WordWidth-1:0] acc,
                                 output logic [WordWidth-1:0] word);
        logic [WordWidth-1:0] z;
        acc = acc + MixGamma;
        z   = acc;
        z   = (z ^ (z >> 30)) * MixMulA;
        z   = (z ^ (z >> 27)) * MixMulB;
        word = z ^ (z >> 31);
    endtask

    // seed: sign-extend, then four splitmix outputs fill words 0..3
    task automatic seed_generator(input logic signed [SeedWidth-1:0] seed);
        logic [WordWidth-1:0] acc;
        logic [WordWidth-1:0] word;
        acc = {{(WordWidth - SeedWidth){seed[SeedWidth-1]}}, seed};
        for (int i = 0; i < NumWords; i++)
        begin
            splitmix_next(acc, word);
            gen_words[i] = word;
        end
    endtask

    // draw: the sum is taken before the xoshiro256 transition
    task automatic draw_generator();
        logic [WordWidth-1:0] sum;
        logic [WordWidth-1:0] carry;
        draw_result_t         res;
        sum   = gen_words[0] + gen_words[3];
        carry = gen_words[1] << XorShift;
        gen_words[2] = gen_words[2] ^ gen_words[0];
        gen_words[3] = gen_words[3] ^ gen_words[1];
        gen_words[1] = gen_words[1] ^ gen_words[2];
        gen_words[0] = gen_words[0] ^ gen_words[3];
        gen_words[2] = gen_words[2] ^ carry;
        gen_words[3] = (gen_words[3] << RotLeft) | (gen_words[3] >> (WordWidth - RotLeft));
        res.raw  = sum;
        res.frac = sum[WordWidth-1:FracShift];
        expected_draws.push_back(res);
    endtask

    // ------------------------------------------------------------------
    // driver: offers queued items, holds the payload while stalled
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            mode       <= ModeSeed;
            seed_value <= '0;
            for (int i = 0; i < NumWords; i++)
            begin
                gen_words[i] = '0;
            end
        end
        else
        begin
            // transfer on the input side: update the prediction
            if (in_valid && !in_stall)
            begin
                if (mode == ModeDraw)
                begin
                    draw_generator();
                end
                else
                begin
                    seed_generator(seed_value);
                end
            end
            // a stalled item stays put; otherwise offer the next one or idle
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_item   = pending_items.pop_front();
                    in_valid   <= 1'b1;
                    mode       <= next_item.mode;
                    seed_value <= next_item.seed;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks each result transfer and drives out_stall
    // ------------------------------------------------------------------
    task automatic check_draw();
        draw_result_t exp_res;
        if (expected_draws.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= MaxReported)
            begin
                $display("%0t: result with nothing expected: raw_value %h uniform_fraction %h",
                         $realtime, raw_value, uniform_fraction);
            end
        end
        else
        begin
            exp_res = expected_draws.pop_front();
            if (raw_value !== exp_res.raw)
            begin
                mismatch_count++;
                if (mismatch_count <= MaxReported)
                begin
                    $display("%0t: raw_value expected %h actual %h",
                             $realtime, exp_res.raw, raw_value);
                end
            end
            if (uniform_fraction !== exp_res.frac)
            begin
                mismatch_count++;
                if (mismatch_count <= MaxReported)
                begin
                    $display("%0t: uniform_fraction expected %h actual %h",
                             $realtime, exp_res.frac, uniform_fraction);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            hold_left   <= 0;
            hold_served <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                check_draw();
            end
            // a fresh hold-off request starts a long stall counted here
            if (hold_ticket != hold_served)
            begin
                hold_served <= hold_ticket;
                hold_left   <= RxHoldCycles;
                out_stall   <= 1'b1;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: no transfer on either side for too long ends the run
    // ------------------------------------------------------------------
    initial
    begin
        do
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                stalled_cycles = 0;
            end
            else
            begin
                stalled_cycles++;
            end
        end
        while (stalled_cycles < WatchdogLimit);
        $display("watchdog: no transfer for %0d cycles", WatchdogLimit);
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic queue_item(input logic m, input logic signed [SeedWidth-1:0] s);
        gen_item_t item;
        item.mode = m;
        item.seed = s;
        pending_items.push_back(item);
    endtask

    // mostly draws, the occasional seed, now and then an extreme seed
    task automatic queue_random(input int count);
        logic signed [SeedWidth-1:0] s;
        for (int i = 0; i < count; i++)
        begin
            s = $urandom;
            if ($urandom_range(99) < 6)
            begin
                if ($urandom_range(7) == 0)
                begin
                    case ($urandom_range(3))
                        0: s = '0;
                        1: s = '1;
                        2: s = {1'b0, {(SeedWidth - 1){1'b1}}};
                        default: s = {1'b1, {(SeedWidth - 1){1'b0}}};
                    endcase
                end
                queue_item(ModeSeed, s);
            end
            else
            begin
                // seed_value is ignored on a draw, keep it random anyway
                queue_item(ModeDraw, s);
            end
        end
    endtask

    // sender pause: nothing offered, nothing outstanding
    task automatic wait_drained();
        @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_draws.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // phase one: sender idles a third of the time, receiver mostly stalls
        @(negedge clk);
        send_idle_pct = 36;
        recv_idle_pct = 87;

        // draws before any seed return zero
        queue_item(ModeDraw, '0);
        queue_item(ModeDraw, '1);
        queue_item(ModeDraw, 32'sh5a5a_a5a5);
        // zero seed, then draws
        queue_item(ModeSeed, '0);
        queue_item(ModeDraw, 32'sh0f0f_f0f0);
        queue_item(ModeDraw, 32'sh7fff_ffff);
        // all-ones seed: negative, sign-extended
        queue_item(ModeSeed, '1);
        queue_item(ModeDraw, '0);
        queue_item(ModeDraw, '0);
        // largest positive and most negative seeds
        queue_item(ModeSeed, 32'sh7fff_ffff);
        queue_item(ModeDraw, 32'sh8000_0000);
        queue_item(ModeDraw, '0);
        queue_item(ModeSeed, 32'sh8000_0000);
        queue_item(ModeDraw, '1);
        queue_item(ModeDraw, '0);
        // back-to-back seeds, only the last one counts
        queue_item(ModeSeed, 32'sh0000_0001);
        queue_item(ModeSeed, 32'sh1234_5678);
        queue_item(ModeDraw, '0);
        queue_item(ModeDraw, '1);
        // seed right after a draw, then a run of draws
        queue_item(ModeSeed, 32'shdead_beef);
        for (int i = 0; i < 4; i++)
        begin
            queue_item(ModeDraw, $urandom);
        end
        wait_drained();

        queue_random(500);
        wait_drained();

        // phase two: roles swapped, plus a long receiver hold-off mid-stream
        send_idle_pct = 87;
        recv_idle_pct = 36;
        queue_random(260);
        hold_ticket++;
        queue_random(260);
        wait_drained();

        // phase three: no idling, hold-off while the sender streams at full rate
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(250);
        hold_ticket++;
        queue_random(255);
        wait_drained();

        // allow a trailing seed to finish and any stray result to show up
        repeat (DrainCycles) @(posedge clk);

        if (mismatch_count == 0 && expected_draws.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: xoshiro256plus_generator_top.f
src/xosh_pkg.sv
src/xosh_ctrl.sv
src/xosh_dp.sv
src/xoshiro256plus_generator_top.sv
sim/xoshiro256plus_generator_top_tb.sv
